// ----- design/spd_pkg.sv -----
// Shared types, constants and fixed-point helpers for the solar position pipeline.
package spd_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int NUM_W = 36;
  localparam int ANG_W = 42;
  localparam int SQ_W = 61;
  localparam int SQ_STEPS = 31;

  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  localparam ang_t Q30_PI         = 42'sd3373259426;
  localparam ang_t Q30_HALF_PI    = 42'sd1686629713;
  localparam ang_t Q30_TWO_PI     = 42'sd6746518852;
  localparam ang_t Q30_FOUR_PI    = 42'sd13493037704;
  localparam num_t Q30_HALF_PI_N  = 36'sd1686629713;
  localparam num_t Q30_ONE        = 36'sd1073741824;
  localparam num_t CORDIC_GAIN    = 36'sd652032874;

  typedef struct packed {
    logic vec;
    logic flip;
    logic zero;
    num_t x;
    num_t y;
    ang_t z;
  } lane_t;

  localparam lane_t LANE_IDLE = '0;

  typedef struct packed {
    num_t lat, sl, cl, sh, ch, sp, dec, sd, cd, sa, ca, ya, xa, alt, az, p1, p2, q;
    ang_t ha, phase;
    logic signed [47:0] decp;
    logic [SQ_W-1:0] sqn;
    logic polar;
  } item_t;

  function automatic num_t atan_at(input int i);
    case (i)
      0:  return 36'sd843314856;
      1:  return 36'sd497837829;
      2:  return 36'sd263043836;
      3:  return 36'sd133525158;
      4:  return 36'sd67021686;
      5:  return 36'sd33543515;
      6:  return 36'sd16775850;
      7:  return 36'sd8388437;
      8:  return 36'sd4194282;
      9:  return 36'sd2097149;
      10: return 36'sd1048575;
      11: return 36'sd524287;
      12: return 36'sd262143;
      13: return 36'sd131071;
      14: return 36'sd65535;
      15: return 36'sd32767;
      16: return 36'sd16383;
      17: return 36'sd8191;
      18: return 36'sd4095;
      19: return 36'sd2047;
      20: return 36'sd1023;
      21: return 36'sd511;
      22: return 36'sd255;
      23: return 36'sd127;
      default: return '0;
    endcase
  endfunction

  // round half up, then floor shift
  function automatic logic signed [71:0] rnd72(input logic signed [71:0] v, input int n);
    return (v + (72'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic num_t mul30(input num_t a, input num_t b);
    logic signed [71:0] p;
    p = a * b;
    return num_t'(rnd72(p, 30));
  endfunction

  function automatic logic signed [15:0] sat16(input num_t v, input num_t lim);
    num_t r;
    r = v;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    return r[15:0];
  endfunction

  // truncating remainder by 2pi, magnitude below 8pi
  function automatic ang_t wrap_rem(input ang_t a);
    ang_t m;
    m = (a < 0) ? -a : a;
    if (m >= Q30_FOUR_PI) m = m - Q30_FOUR_PI;
    if (m >= Q30_TWO_PI) m = m - Q30_TWO_PI;
    return (a < 0) ? -m : m;
  endfunction

  function automatic lane_t lane_wrap(input lane_t l);
    lane_t r;
    r = l;
    if (!l.vec) r.z = wrap_rem(l.z);
    return r;
  endfunction

  function automatic lane_t lane_prep(input lane_t l);
    lane_t r;
    ang_t a;
    r = l;
    if (!l.vec) begin
      a = l.z;
      r.flip = 1'b0;
      if (a > Q30_PI) a = a - Q30_TWO_PI;
      else if (a < -Q30_PI) a = a + Q30_TWO_PI;
      if (a > Q30_HALF_PI) begin
        a = a - Q30_PI;
        r.flip = 1'b1;
      end else if (a < -Q30_HALF_PI) begin
        a = a + Q30_PI;
        r.flip = 1'b1;
      end
      r.x = CORDIC_GAIN;
      r.y = '0;
      r.z = a;
    end else begin
      r.zero = (l.x == 0) && (l.y == 0);
      r.z = '0;
      if (l.x < 0) begin
        r.z = (l.y >= 0) ? Q30_PI : -Q30_PI;
        r.x = -l.x;
        r.y = -l.y;
      end
    end
    return r;
  endfunction

  function automatic lane_t lane_step(input lane_t l, input int i);
    lane_t r;
    num_t dx, dy;
    r = l;
    dx = l.y >>> i;
    dy = l.x >>> i;
    if (l.vec ? (l.y >= 0) : (l.z < 0)) begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + ang_t'(atan_at(i));
    end else begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - ang_t'(atan_at(i));
    end
    return r;
  endfunction

  // rotation lanes leave cos in x and sin in y; vectoring lanes the angle in z
  function automatic lane_t lane_finish(input lane_t l);
    lane_t r;
    r = l;
    if (l.vec) begin
      if (l.zero) r.z = '0;
    end else if (l.flip) begin
      r.x = -l.x;
      r.y = -l.y;
    end
    return r;
  endfunction

endpackage

// ----- design/spd_cordic.sv -----
// Three-lane pipelined CORDIC: angle reduction, fold, iterations, sign fixup.
module spd_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  spd_pkg::item_t     item_i,
  input  spd_pkg::lane_t     lane_i [3],
  output logic               valid_o,
  output spd_pkg::item_t     item_o,
  output spd_pkg::lane_t     lane_o [3]
);
  import spd_pkg::*;

  localparam int DEPTH = CORDIC_STAGES + 3;

  logic  valid_q [DEPTH];
  item_t item_q  [DEPTH];
  lane_t lane_q  [DEPTH][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DEPTH; s++) valid_q[s] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int s = 1; s < DEPTH; s++) valid_q[s] <= valid_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q[0] <= item_i;
      for (int s = 1; s < DEPTH; s++) item_q[s] <= item_q[s-1];
      for (int l = 0; l < 3; l++) begin
        lane_q[0][l] <= lane_wrap(lane_i[l]);
        lane_q[1][l] <= lane_prep(lane_q[0][l]);
        for (int s = 2; s < CORDIC_STAGES + 2; s++) begin
          lane_q[s][l] <= lane_step(lane_q[s-1][l], s - 2);
        end
        lane_q[DEPTH-1][l] <= lane_finish(lane_q[DEPTH-2][l]);
      end
    end
  end

  assign valid_o = valid_q[DEPTH-1];
  assign item_o  = item_q[DEPTH-1];
  assign lane_o  = lane_q[DEPTH-1];

endmodule

// ----- design/spd_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, fills item.ca.
module spd_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  spd_pkg::item_t item_i,
  output logic           valid_o,
  output spd_pkg::item_t item_o
);
  import spd_pkg::*;

  logic        valid_q [SQ_STEPS];
  item_t       item_q  [SQ_STEPS];
  logic [61:0] rem_q   [SQ_STEPS];
  logic [61:0] res_q   [SQ_STEPS];

  function automatic logic [123:0] sq_step(input logic [61:0] rem, input logic [61:0] res,
                                           input int k);
    logic [61:0] pw, sum, nrem, nres;
    pw = 62'd1 << (2 * k);
    sum = res + pw;
    if (rem >= sum) begin
      nrem = rem - sum;
      nres = (res >> 1) + pw;
    end else begin
      nrem = rem;
      nres = res >> 1;
    end
    return {nrem, nres};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SQ_STEPS; s++) valid_q[s] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int s = 1; s < SQ_STEPS; s++) valid_q[s] <= valid_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q[0] <= item_i;
      {rem_q[0], res_q[0]} <= sq_step(62'(item_i.sqn), '0, SQ_STEPS - 1);
      for (int s = 1; s < SQ_STEPS; s++) begin
        item_q[s] <= item_q[s-1];
        {rem_q[s], res_q[s]} <= sq_step(rem_q[s-1], res_q[s-1], SQ_STEPS - 1 - s);
      end
    end
  end

  always_comb begin
    item_o    = item_q[SQ_STEPS-1];
    item_o.ca = num_t'(res_q[SQ_STEPS-1]);
  end

  assign valid_o = valid_q[SQ_STEPS-1];

endmodule

// ----- design/solar_position_direction.sv -----
// Solar altitude, azimuth and direction vector pipeline (top level).
// Throughput: one item per cycle; a stall at the output freezes the whole pipeline in place.
// The path runs through the four CORDIC pipelines and the 31-stage square root, one step a stage.
// Reset clears all valid bits and loads hour-angle rate 17157 and declination amplitude 6703.
module solar_position_direction (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic [20:0]         hour_of_day_i,
  input  logic [15:0]         day_of_year_i,
  input  logic signed [15:0]  observer_latitude_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic [16:0]         azimuth_o,
  output logic signed [15:0]  altitude_o,
  output logic signed [15:0]  dir_x_o,
  output logic signed [15:0]  dir_y_o,
  output logic signed [15:0]  dir_z_o
);
  import spd_pkg::*;

  localparam logic REG_HA_RATE  = 1'b0;
  localparam logic REG_DECL_AMP = 1'b1;
  localparam logic signed [15:0] LAT_LIM = 16'sd25736;
  localparam logic signed [21:0] HOUR_NOON = 22'sd786432;
  localparam logic signed [16:0] DAY_OFFSET = 17'sd10368;
  localparam logic signed [25:0] DAY_STEP = 26'sd18483613;
  localparam num_t ALT_LIM = 36'sd25736;
  localparam num_t DIR_LIM = 36'sd16384;
  localparam num_t AZ_WRAP = 36'sd102944;

  logic [15:0] ha_rate_q;
  logic [14:0] decl_amp_q;

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ha_rate_q  <= 16'd17157;
      decl_amp_q <= 15'd6703;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_HA_RATE:  ha_rate_q  <= pwdata[15:0];
        REG_DECL_AMP: decl_amp_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DECL_AMP) ? {17'd0, decl_amp_q} : {16'd0, ha_rate_q};

  logic adv;
  logic out_valid_q;
  assign adv     = !(out_valid_q && stall_i);
  assign stall_o = !adv;

  logic  v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q;
  item_t it0_q, it1_q, it2_q, it3_q, it4_q, it5_q, it6_q, it7_q, it8_q, it9_q, it10_q, it11_q;
  item_t it0_d, it1_d, it2_d, it3_d, it4_d, it5_d, it6_d, it7_d, it8_d, it9_d, it10_d, it11_d;
  logic [16:0]        azimuth_d;
  logic signed [15:0] altitude_d, dir_x_d, dir_y_d, dir_z_d;

  logic  c1_v, c2_v, c3_v, c4_v, sq_v;
  item_t c1_it, c2_it, c3_it, c4_it, sq_it;
  lane_t c1_in [3], c1_out [3], c2_in [3], c2_out [3];
  lane_t c3_in [3], c3_out [3], c4_in [3], c4_out [3];

  // input stage arithmetic
  logic signed [15:0] lat_sat;
  logic signed [21:0] hour_d;
  logic signed [38:0] hour_p;
  logic signed [16:0] day_d;
  logic signed [41:0] day_p;

  always_comb begin
    lat_sat = observer_latitude_i;
    if (observer_latitude_i > LAT_LIM) lat_sat = LAT_LIM;
    else if (observer_latitude_i < -LAT_LIM) lat_sat = -LAT_LIM;
    hour_d = $signed({1'b0, hour_of_day_i}) - HOUR_NOON;
    hour_p = hour_d * $signed({1'b0, ha_rate_q});
    day_d  = $signed({1'b0, day_of_year_i}) - DAY_OFFSET;
    day_p  = day_d * DAY_STEP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q} <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v0_q  <= valid_i;
      v1_q  <= v0_q;
      v2_q  <= c1_v;
      v3_q  <= v2_q;
      v4_q  <= c2_v;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= sq_v;
      v10_q <= c3_v;
      v11_q <= c4_v;
      out_valid_q <= v11_q;
    end
  end

  logic signed [NUM_W:0]  sa_sum;
  logic signed [71:0]     sa_sq;
  ang_t                   az_w;
  num_t                   az14;

  always_comb begin
    sa_sum = (NUM_W+1)'(it5_q.p1) + (NUM_W+1)'(it5_q.p2);
    sa_sq  = it6_q.sa * it6_q.sa;
    az_w   = c3_out[1].z;
    if (az_w < 0) az_w = az_w + Q30_TWO_PI;
    if (c3_it.polar) az_w = '0;
    az14 = num_t'(rnd72(72'(it11_q.az), 16));
  end

  always_comb begin
    it0_d       = '0;
    it0_d.lat   = num_t'(lat_sat) <<< 16;
    it0_d.ha    = ang_t'(hour_p);
    it0_d.phase = day_p;

    it1_d       = it0_q;
    it1_d.ha    = ang_t'(rnd72(72'(it0_q.ha), 2));
    it1_d.phase = ang_t'(rnd72(72'(it0_q.phase), 7));

    it2_d      = c1_it;
    it2_d.sp   = c1_out[0].y;
    it2_d.sl   = c1_out[1].y;
    it2_d.cl   = c1_out[1].x;
    it2_d.sh   = c1_out[2].y;
    it2_d.ch   = c1_out[2].x;
    it2_d.decp = c1_out[0].y * $signed({1'b0, decl_amp_q});

    it3_d     = it2_q;
    it3_d.dec = num_t'(rnd72(72'(it2_q.decp), 14));

    it4_d    = c2_it;
    it4_d.sd = c2_out[0].y;
    it4_d.cd = c2_out[0].x;
    it4_d.p1 = mul30(c2_out[0].y, c2_it.sl);
    it4_d.p2 = mul30(c2_out[0].x, c2_it.cl);
    it4_d.q  = mul30(c2_out[0].x, c2_it.sh);

    it5_d    = it4_q;
    it5_d.p2 = mul30(it4_q.p2, it4_q.ch);
    it5_d.ya = -mul30(it4_q.q, it4_q.cl);

    it6_d = it5_q;
    if (sa_sum > (NUM_W+1)'(Q30_ONE)) it6_d.sa = Q30_ONE;
    else if (sa_sum < -(NUM_W+1)'(Q30_ONE)) it6_d.sa = -Q30_ONE;
    else it6_d.sa = num_t'(sa_sum);

    it7_d     = it6_q;
    it7_d.sqn = SQ_W'((72'sd1 <<< 60) - sa_sq);
    it7_d.p1  = mul30(it6_q.sl, it6_q.sa);

    it8_d       = it7_q;
    it8_d.xa    = it7_q.sd - it7_q.p1;
    it8_d.polar = (rnd72(72'(it7_q.cl), 16) <= 0);

    it9_d       = sq_it;
    it9_d.polar = sq_it.polar || (rnd72(72'(sq_it.ca), 16) <= 0);

    it10_d = c3_it;
    if (c3_out[0].z > ang_t'(Q30_HALF_PI_N)) it10_d.alt = Q30_HALF_PI_N;
    else if (c3_out[0].z < -ang_t'(Q30_HALF_PI_N)) it10_d.alt = -Q30_HALF_PI_N;
    else it10_d.alt = num_t'(c3_out[0].z);
    it10_d.az = num_t'(az_w);

    it11_d    = c4_it;
    it11_d.p1 = mul30(c4_it.ca, c4_out[0].y);
    it11_d.p2 = mul30(c4_it.ca, c4_out[0].x);

    azimuth_d  = (az14 >= AZ_WRAP || az14 < 0) ? '0 : az14[16:0];
    altitude_d = sat16(num_t'(rnd72(72'(it11_q.alt), 16)), ALT_LIM);
    dir_x_d    = sat16(num_t'(rnd72(72'(it11_q.p1), 16)), DIR_LIM);
    dir_y_d    = sat16(num_t'(rnd72(72'(it11_q.sa), 16)), DIR_LIM);
    dir_z_d    = sat16(num_t'(rnd72(72'(it11_q.p2), 16)), DIR_LIM);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it0_q      <= it0_d;
      it1_q      <= it1_d;
      it2_q      <= it2_d;
      it3_q      <= it3_d;
      it4_q      <= it4_d;
      it5_q      <= it5_d;
      it6_q      <= it6_d;
      it7_q      <= it7_d;
      it8_q      <= it8_d;
      it9_q      <= it9_d;
      it10_q     <= it10_d;
      it11_q     <= it11_d;
      azimuth_o  <= azimuth_d;
      altitude_o <= altitude_d;
      dir_x_o    <= dir_x_d;
      dir_y_o    <= dir_y_d;
      dir_z_o    <= dir_z_d;
    end
  end

  assign valid_o = out_valid_q;

  always_comb begin
    c1_in[0] = LANE_IDLE;
    c1_in[1] = LANE_IDLE;
    c1_in[2] = LANE_IDLE;
    c1_in[0].z = it1_q.phase;
    c1_in[1].z = ang_t'(it1_q.lat);
    c1_in[2].z = it1_q.ha;

    c2_in[0] = LANE_IDLE;
    c2_in[1] = LANE_IDLE;
    c2_in[2] = LANE_IDLE;
    c2_in[0].z = ang_t'(it3_q.dec);

    c3_in[0] = LANE_IDLE;
    c3_in[1] = LANE_IDLE;
    c3_in[2] = LANE_IDLE;
    c3_in[0].vec = 1'b1;
    c3_in[0].x = it9_q.ca;
    c3_in[0].y = it9_q.sa;
    c3_in[1].vec = 1'b1;
    c3_in[1].x = it9_q.xa;
    c3_in[1].y = it9_q.ya;

    c4_in[0] = LANE_IDLE;
    c4_in[1] = LANE_IDLE;
    c4_in[2] = LANE_IDLE;
    c4_in[0].z = ang_t'(it10_q.az);
  end

  spd_cordic u_cordic_base (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v1_q), .item_i(it1_q), .lane_i(c1_in),
    .valid_o(c1_v), .item_o(c1_it), .lane_o(c1_out)
  );

  spd_cordic u_cordic_dec (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v3_q), .item_i(it3_q), .lane_i(c2_in),
    .valid_o(c2_v), .item_o(c2_it), .lane_o(c2_out)
  );

  spd_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v8_q), .item_i(it8_q),
    .valid_o(sq_v), .item_o(sq_it)
  );

  spd_cordic u_cordic_atan (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v9_q), .item_i(it9_q), .lane_i(c3_in),
    .valid_o(c3_v), .item_o(c3_it), .lane_o(c3_out)
  );

  spd_cordic u_cordic_az (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v10_q), .item_i(it10_q), .lane_i(c4_in),
    .valid_o(c4_v), .item_o(c4_it), .lane_o(c4_out)
  );

endmodule

// ----- design/spd_checker.sv -----
// Port-level checks for the solar position block, bound to the top level.
module spd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               pready,
  input logic               valid_o,
  input logic               stall_i,
  input logic               stall_o,
  input logic [16:0]        azimuth_o,
  input logic signed [15:0] altitude_o,
  input logic signed [15:0] dir_y_o
);

  // input side only backs up when a result is held at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i)) else $error("stall_o without held result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(azimuth_o) && $stable(altitude_o)))
    else $error("stalled result changed");

  a_az_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (azimuth_o <= 17'd102943)) else $error("azimuth out of range");

  a_alt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (altitude_o <= 16'sd25736 && altitude_o >= -16'sd25736))
    else $error("altitude out of range");

  a_diry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && pready) |-> (dir_y_o <= 16'sd16384 && dir_y_o >= -16'sd16384))
    else $error("dir_y out of range");

endmodule

bind solar_position_direction spd_checker u_spd_checker (.*);
